@@ rtl/adamw_element_update_macros.svh @@
// Assertion macros shared by the AdamW element update RTL.
`ifndef ADAMW_ELEMENT_UPDATE_MACROS_SVH
`define ADAMW_ELEMENT_UPDATE_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ADAMW_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication checked at every clock edge out of reset.
`define ADAMW_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/adamw_pkg.sv @@
// Shared types, register codes and helpers for the AdamW element update.
package adamw_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRACTION_BITS = 24;
  localparam int CFG_BITS      = FRACTION_BITS + 1;
  localparam int CFG_IDX_BITS  = 3;
  localparam int P1_W          = WORD_BITS + 3;

  localparam longint unsigned HALF = 64'd1 << (FRACTION_BITS - 1);

  typedef logic [CFG_BITS-1:0] cfg_word_t;

  localparam cfg_word_t ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  localparam logic [CFG_IDX_BITS-1:0] REG_LEARNING_RATE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BETA_FIRST    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BETA_SECOND   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_EPSILON       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_RATE    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BIAS_FIRST    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_BIAS_SECOND   = 3'd6;

  localparam cfg_word_t RST_LEARNING_RATE = 25'd16777;
  localparam cfg_word_t RST_BETA_FIRST    = 25'd15099494;
  localparam cfg_word_t RST_BETA_SECOND   = 25'd16760439;
  localparam cfg_word_t RST_EPSILON       = 25'd1;
  localparam cfg_word_t RST_DECAY_RATE    = 25'd167772;

  typedef struct packed {
    cfg_word_t lr;
    cfg_word_t b1;
    cfg_word_t b2;
    cfg_word_t eps;
    cfg_word_t wd;
    cfg_word_t d1;
    cfg_word_t d2;
  } cfg_t;

  typedef struct packed {
    logic signed [P1_W-1:0]      p1;
    logic signed [WORD_BITS-1:0] mn;
    logic [WORD_BITS-1:0]        vn;
    logic                        sat;
  } front_t;

  function automatic cfg_word_t cap_one(input cfg_word_t x);
    return (x > ONE) ? ONE : x;
  endfunction

endpackage

@@ rtl/adamw_isqrt_pipe.sv @@
// Pipelined floor square root, one result bit per stage, with side data.
module adamw_isqrt_pipe #(
  parameter int ARG_W  = 56,
  parameter int SIDE_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [ARG_W-1:0]     in_arg,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic [ARG_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]    out_side
);
  localparam int ROOT_W = ARG_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int TRY_W  = REM_W + 2;

  logic              vld  [ROOT_W];
  logic [REM_W-1:0]  rem  [ROOT_W];
  logic [ROOT_W-1:0] root [ROOT_W];
  logic [ARG_W-1:0]  arg  [ROOT_W];
  logic [SIDE_W-1:0] side [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic              c_vld;
    logic [REM_W-1:0]  c_rem;
    logic [ROOT_W-1:0] c_root;
    logic [ARG_W-1:0]  c_arg;
    logic [SIDE_W-1:0] c_side;
    logic [TRY_W-1:0]  t;
    logic [TRY_W-1:0]  trial;
    logic [TRY_W-1:0]  nrem;
    logic              fits;

    if (k == 0) begin : g_head
      assign c_vld  = in_valid;
      assign c_rem  = '0;
      assign c_root = '0;
      assign c_arg  = in_arg;
      assign c_side = in_side;
    end else begin : g_body
      assign c_vld  = vld[k-1];
      assign c_rem  = rem[k-1];
      assign c_root = root[k-1];
      assign c_arg  = arg[k-1];
      assign c_side = side[k-1];
    end

    // bring down the next two bits and try 4*root+1
    assign t     = {c_rem, c_arg[ARG_W-1 -: 2]};
    assign trial = TRY_W'({c_root, 2'b01});
    assign fits  = (t >= trial);
    assign nrem  = fits ? (t - trial) : t;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= nrem[REM_W-1:0];
        root[k] <= {c_root[ROOT_W-2:0], fits};
        arg[k]  <= c_arg << 2;
        side[k] <= c_side;
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign out_root  = root[ROOT_W-1];
  assign out_side  = side[ROOT_W-1];

endmodule

@@ rtl/adamw_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, with side data.
module adamw_div_pipe #(
  parameter int NUM_W  = 56,
  parameter int DEN_W  = 25,
  parameter int QUO_W  = 56,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QUO_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);
  logic              vld  [QUO_W];
  logic [DEN_W-1:0]  rem  [QUO_W];
  logic [QUO_W-1:0]  lo   [QUO_W];
  logic [DEN_W-1:0]  den  [QUO_W];
  logic [SIDE_W-1:0] side [QUO_W];

  // upper numerator bits start as the partial remainder (below the divisor)
  logic [NUM_W-1:0] num_top;
  assign num_top = in_num >> QUO_W;

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic              c_vld;
    logic [DEN_W-1:0]  c_rem;
    logic [QUO_W-1:0]  c_lo;
    logic [DEN_W-1:0]  c_den;
    logic [SIDE_W-1:0] c_side;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    if (k == 0) begin : g_head
      assign c_vld  = in_valid;
      assign c_rem  = num_top[DEN_W-1:0];
      assign c_lo   = in_num[QUO_W-1:0];
      assign c_den  = in_den;
      assign c_side = in_side;
    end else begin : g_body
      assign c_vld  = vld[k-1];
      assign c_rem  = rem[k-1];
      assign c_lo   = lo[k-1];
      assign c_den  = den[k-1];
      assign c_side = side[k-1];
    end

    assign trial = {c_rem, c_lo[QUO_W-1]};
    assign fits  = (trial >= {1'b0, c_den});
    assign diff  = trial - {1'b0, c_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= c_vld;
      end
    end

    // numerator bits shift out the top while quotient bits shift in below
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        lo[k]   <= {c_lo[QUO_W-2:0], fits};
        den[k]  <= c_den;
        side[k] <= c_side;
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign out_quo   = lo[QUO_W-1];
  assign out_side  = side[QUO_W-1];

endmodule

@@ rtl/adamw_front.sv @@
// Moment decay and weight decay front end: four register stages.
module adamw_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic signed [adamw_pkg::WORD_BITS-1:0] param_value,
  input  logic signed [adamw_pkg::WORD_BITS-1:0] gradient,
  input  logic signed [adamw_pkg::WORD_BITS-1:0] first_moment,
  input  logic [adamw_pkg::WORD_BITS-1:0]        second_moment,
  input  adamw_pkg::cfg_t                        cfg,
  input  adamw_pkg::cfg_word_t                   lw,
  output logic                                   out_valid,
  output adamw_pkg::front_t                      out_data
);
  import adamw_pkg::*;

  localparam int W     = WORD_BITS;
  localparam int F     = FRACTION_BITS;
  localparam int MP_W  = CFG_BITS + 1 + W;
  localparam int MS_W  = MP_W + 1;
  localparam int MR_W  = MS_W - F;
  localparam int G2_W  = 2 * W;
  localparam int GSQ_W = 2 * W - 1 - F;
  localparam int V1_W  = CFG_BITS + W;
  localparam int V2_W  = CFG_BITS + GSQ_W;
  localparam int VS_W  = V2_W + 1;
  localparam int VR_W  = VS_W - F;
  localparam int LR_W  = MP_W - F;

  // stage A: products of the first moment and the squared gradient
  logic                    a_valid;
  logic signed [MP_W-1:0]  pm_a;
  logic signed [MP_W-1:0]  pg_a;
  logic signed [G2_W-1:0]  g2_a;
  logic signed [W-1:0]     p_a;
  logic [W-1:0]            v_a;
  logic signed [CFG_BITS:0] b1_s;
  logic signed [CFG_BITS:0] b1c_s;

  assign b1_s  = {1'b0, cfg.b1};
  assign b1c_s = {1'b0, ONE - cfg.b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm_a <= b1_s * first_moment;
      pg_a <= b1c_s * gradient;
      g2_a <= gradient * gradient;
      p_a  <= param_value;
      v_a  <= second_moment;
    end
  end

  // stage B: round the first moment, round the squared gradient
  logic                 b_valid;
  logic signed [W-1:0]  mn_b;
  logic                 satm_b;
  logic [GSQ_W-1:0]     gsq_b;
  logic signed [W-1:0]  p_b;
  logic [W-1:0]         v_b;
  logic [MS_W-1:0]      msum;
  logic [MS_W-1:0]      madj;
  logic [MR_W-1:0]      mr;
  logic                 m_ovf;
  logic [G2_W-1:0]      g2_adj;

  // ties away from zero: subtract one before the floor shift on negatives
  assign msum   = MS_W'(pm_a) + MS_W'(pg_a);
  assign madj   = msum + MS_W'(HALF) - MS_W'(msum[MS_W-1]);
  assign mr     = madj[MS_W-1:F];
  assign m_ovf  = (mr[MR_W-1:W-1] != '0) && (mr[MR_W-1:W-1] != '1);
  assign g2_adj = g2_a + G2_W'(HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mn_b   <= m_ovf ? (mr[MR_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
                      : mr[W-1:0];
      satm_b <= m_ovf;
      gsq_b  <= g2_adj[G2_W-2:F];
      p_b    <= p_a;
      v_b    <= v_a;
    end
  end

  // stage C: second moment products and the weight decay product
  logic                    c_valid;
  logic [V1_W-1:0]         pv1_c;
  logic [V2_W-1:0]         pv2_c;
  logic signed [MP_W-1:0]  lwp_c;
  logic signed [W-1:0]     mn_c;
  logic                    satm_c;
  logic signed [W-1:0]     p_c;
  logic signed [CFG_BITS:0] lw_s;
  logic [CFG_BITS-1:0]     b2c;

  assign lw_s = {1'b0, lw};
  assign b2c  = ONE - cfg.b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pv1_c  <= cfg.b2 * v_b;
      pv2_c  <= b2c * gsq_b;
      lwp_c  <= lw_s * p_b;
      mn_c   <= mn_b;
      satm_c <= satm_b;
      p_c    <= p_b;
    end
  end

  // stage D: round the second moment, apply decoupled weight decay
  logic [VS_W-1:0]       vsum;
  logic [VR_W-1:0]       vr;
  logic                  v_ovf;
  logic [MP_W-1:0]       lwadj;
  logic signed [LR_W-1:0] lwr;

  assign vsum  = VS_W'(pv1_c) + VS_W'(pv2_c) + VS_W'(HALF);
  assign vr    = vsum[VS_W-1:F];
  assign v_ovf = (vr[VR_W-1:W] != '0);
  assign lwadj = lwp_c + MP_W'(HALF) - MP_W'(lwp_c[MP_W-1]);
  assign lwr   = lwadj[MP_W-1:F];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.p1  <= P1_W'(p_c) - P1_W'(lwr);
      out_data.mn  <= mn_c;
      out_data.vn  <= v_ovf ? '1 : vr[W-1:0];
      out_data.sat <= satm_c | v_ovf;
    end
  end

endmodule

@@ rtl/adamw_element_update.sv @@
// AdamW element update top level: one parameter element per word.
// Throughput: one word per cycle while the output is not stalled;
// the whole pipeline advances together.
// Pipeline depth is set by the bit-serial square root and three dividers.
// Reset (rst, synchronous): registers return to defaults, pipeline empties.
`include "adamw_element_update_macros.svh"

module adamw_element_update (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [adamw_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [adamw_pkg::CFG_BITS-1:0]        cfg_data,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // param_value [31:0], gradient [63:32], first_moment [95:64],
  // second_moment [127:96]
  input  logic [4*adamw_pkg::WORD_BITS-1:0]     s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // new_param [31:0], new_first_moment [63:32], new_second_moment [95:64]
  output logic [3*adamw_pkg::WORD_BITS-1:0]     m_tdata,
  // saturated [0]
  output logic                                  m_tuser
);
  import adamw_pkg::*;

  localparam int W      = WORD_BITS;
  localparam int F      = FRACTION_BITS;
  localparam int SQ_W   = W + F;
  localparam int RT_W   = SQ_W / 2;
  localparam int SVN_W  = RT_W + F + 1;
  localparam int SV_W   = RT_W + F - F / 2 + 1;
  localparam int DEN_W  = SV_W + 1;
  localparam int MHN_W  = W + F;
  localparam int SPLIT  = W;
  localparam int UN_W   = CFG_BITS + MHN_W;
  localparam int STEP_W = 2 * W - 1;
  localparam int PN_W   = 2 * W;

  localparam logic [STEP_W-1:0] STEP_CAP = {1'b1, {(STEP_W-1){1'b0}}};
  localparam logic [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic signed [P1_W-1:0] p1;
    logic [W-1:0]           vn;
    logic                   sat;
  } sqv_side_t;

  typedef struct packed {
    logic signed [P1_W-1:0] p1;
    logic [W-1:0]           vn;
    logic signed [W-1:0]    mn;
    logic                   sat;
  } sv_side_t;

  typedef struct packed {
    logic signed [P1_W-1:0] p1;
    logic [W-1:0]           vn;
    logic signed [W-1:0]    mn;
    logic                   sat;
    logic [DEN_W-1:0]       den;
  } mh_side_t;

  typedef struct packed {
    logic signed [P1_W-1:0] p1;
    logic [W-1:0]           vn;
    logic signed [W-1:0]    mn;
    logic                   sat;
    logic                   big;
  } u_side_t;

  // configuration registers
  cfg_t cfg_q;
  cfg_t cfgc;
  cfg_word_t lw;
  logic [2*CFG_BITS-1:0] lw_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.lr  <= RST_LEARNING_RATE;
      cfg_q.b1  <= RST_BETA_FIRST;
      cfg_q.b2  <= RST_BETA_SECOND;
      cfg_q.eps <= RST_EPSILON;
      cfg_q.wd  <= RST_DECAY_RATE;
      cfg_q.d1  <= ONE;
      cfg_q.d2  <= ONE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LEARNING_RATE: cfg_q.lr  <= cfg_data;
        REG_BETA_FIRST:    cfg_q.b1  <= cfg_data;
        REG_BETA_SECOND:   cfg_q.b2  <= cfg_data;
        REG_EPSILON:       cfg_q.eps <= cfg_data;
        REG_DECAY_RATE:    cfg_q.wd  <= cfg_data;
        REG_BIAS_FIRST:    cfg_q.d1  <= cfg_data;
        REG_BIAS_SECOND:   cfg_q.d2  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp every register to one; a zero bias denominator acts as one LSB
  always_comb begin
    cfgc.lr  = cap_one(cfg_q.lr);
    cfgc.b1  = cap_one(cfg_q.b1);
    cfgc.b2  = cap_one(cfg_q.b2);
    cfgc.eps = cap_one(cfg_q.eps);
    cfgc.wd  = cap_one(cfg_q.wd);
    cfgc.d1  = (cfg_q.d1 == '0) ? CFG_BITS'(1) : cap_one(cfg_q.d1);
    cfgc.d2  = (cfg_q.d2 == '0) ? CFG_BITS'(1) : cap_one(cfg_q.d2);
  end

  // lr*wd depends on registers alone; settle it once per cycle
  assign lw_sum = cfgc.lr * cfgc.wd + (2*CFG_BITS)'(HALF);

  always_ff @(posedge clk) begin
    lw <= lw_sum[F +: CFG_BITS];
  end

  // global advance: the output register drains or is empty
  logic en;
  logic out_valid;

  assign en       = !out_valid || m_tready;
  assign s_tready = en;

  // front end
  logic   fr_valid;
  front_t fr_data;

  adamw_front u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (s_tvalid),
    .param_value   (s_tdata[0 +: W]),
    .gradient      (s_tdata[W +: W]),
    .first_moment  (s_tdata[2*W +: W]),
    .second_moment (s_tdata[3*W +: W]),
    .cfg           (cfgc),
    .lw            (lw),
    .out_valid     (fr_valid),
    .out_data      (fr_data)
  );

  // square roots of v and of the second bias denominator, side by side
  sqv_side_t       sqv_in_side;
  sqv_side_t       sqv_side;
  logic            sqv_valid;
  logic [RT_W-1:0] sqv_root;
  logic            sqd_valid;
  logic [RT_W-1:0] sqd_root;
  logic [W-1:0]    sqd_mn;

  assign sqv_in_side.p1  = fr_data.p1;
  assign sqv_in_side.vn  = fr_data.vn;
  assign sqv_in_side.sat = fr_data.sat;

  adamw_isqrt_pipe #(
    .ARG_W  (SQ_W),
    .SIDE_W ($bits(sqv_side_t))
  ) u_sqrt_v (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .in_arg    ({fr_data.vn, F'(0)}),
    .in_side   (sqv_in_side),
    .out_valid (sqv_valid),
    .out_root  (sqv_root),
    .out_side  (sqv_side)
  );

  adamw_isqrt_pipe #(
    .ARG_W  (SQ_W),
    .SIDE_W (W)
  ) u_sqrt_d (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .in_arg    (SQ_W'({cfgc.d2, F'(0)})),
    .in_side   (fr_data.mn),
    .out_valid (sqd_valid),
    .out_root  (sqd_root),
    .out_side  (sqd_mn)
  );

  // sqrt(v_hat) = rnd(sqrt(v) * one / sqrt(d2))
  logic [CFG_BITS-1:0] sd2;
  logic [SVN_W-1:0]    sv_num;
  sv_side_t            sv_in_side;
  sv_side_t            sv_side;
  logic                sv_valid;
  logic [SV_W-1:0]     sv_quo;

  assign sd2    = sqd_root[CFG_BITS-1:0];
  assign sv_num = SVN_W'({sqv_root, F'(0)}) + SVN_W'(sd2 >> 1);

  assign sv_in_side.p1  = sqv_side.p1;
  assign sv_in_side.vn  = sqv_side.vn;
  assign sv_in_side.mn  = sqd_mn;
  assign sv_in_side.sat = sqv_side.sat;

  adamw_div_pipe #(
    .NUM_W  (SVN_W),
    .DEN_W  (CFG_BITS),
    .QUO_W  (SV_W),
    .SIDE_W ($bits(sv_side_t))
  ) u_div_sv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sqv_valid),
    .in_num    (sv_num),
    .in_den    (sd2),
    .in_side   (sv_in_side),
    .out_valid (sv_valid),
    .out_quo   (sv_quo),
    .out_side  (sv_side)
  );

  // m_hat = rnd(|m| * one / d1), with the step denominator riding along
  logic [DEN_W-1:0] den_raw;
  logic [W-1:0]     mn_u;
  logic [W-1:0]     mn_mag;
  logic [MHN_W-1:0] mh_num;
  mh_side_t         mh_in_side;
  mh_side_t         mh_side;
  logic             mh_valid;
  logic [MHN_W-1:0] mh_quo;

  assign den_raw = DEN_W'(sv_quo) + DEN_W'(cfgc.eps);
  assign mn_u    = sv_side.mn;
  assign mn_mag  = mn_u[W-1] ? (~mn_u + W'(1)) : mn_u;
  assign mh_num  = MHN_W'({mn_mag, F'(0)}) + MHN_W'(cfgc.d1 >> 1);

  assign mh_in_side.p1  = sv_side.p1;
  assign mh_in_side.vn  = sv_side.vn;
  assign mh_in_side.mn  = sv_side.mn;
  assign mh_in_side.sat = sv_side.sat;
  assign mh_in_side.den = (den_raw == '0) ? DEN_W'(1) : den_raw;

  adamw_div_pipe #(
    .NUM_W  (MHN_W),
    .DEN_W  (CFG_BITS),
    .QUO_W  (MHN_W),
    .SIDE_W ($bits(mh_side_t))
  ) u_div_mh (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sv_valid),
    .in_num    (mh_num),
    .in_den    (cfgc.d1),
    .in_side   (mh_in_side),
    .out_valid (mh_valid),
    .out_quo   (mh_quo),
    .out_side  (mh_side)
  );

  // lr * m_hat in two partial products, then summed with den/2
  logic                         m1_valid;
  logic [CFG_BITS+SPLIT-1:0]    pp_lo;
  logic [CFG_BITS+MHN_W-SPLIT-1:0] pp_hi;
  mh_side_t                     m1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= mh_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_lo   <= cfgc.lr * mh_quo[SPLIT-1:0];
      pp_hi   <= cfgc.lr * mh_quo[MHN_W-1:SPLIT];
      m1_side <= mh_side;
    end
  end

  logic             m2_valid;
  logic [UN_W-1:0]  m2_num;
  logic [DEN_W-1:0] m2_den;
  u_side_t          m2_side;
  logic [UN_W-1:0]  u_num;

  assign u_num = UN_W'(pp_lo) + (UN_W'(pp_hi) << SPLIT) + UN_W'(m1_side.den >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (en) begin
      m2_valid <= m1_valid;
    end
  end

  // a quotient at or above 2^STEP_W is flagged here and capped later
  always_ff @(posedge clk) begin
    if (en) begin
      m2_num      <= u_num;
      m2_den      <= m1_side.den;
      m2_side.p1  <= m1_side.p1;
      m2_side.vn  <= m1_side.vn;
      m2_side.mn  <= m1_side.mn;
      m2_side.sat <= m1_side.sat;
      m2_side.big <= (u_num >> STEP_W) >= UN_W'(m1_side.den);
    end
  end

  logic              ud_valid;
  logic [STEP_W-1:0] ud_quo;
  u_side_t           ud_side;

  adamw_div_pipe #(
    .NUM_W  (UN_W),
    .DEN_W  (DEN_W),
    .QUO_W  (STEP_W),
    .SIDE_W ($bits(u_side_t))
  ) u_div_step (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m2_valid),
    .in_num    (m2_num),
    .in_den    (m2_den),
    .in_side   (m2_side),
    .out_valid (ud_valid),
    .out_quo   (ud_quo),
    .out_side  (ud_side)
  );

  // apply the step against the sign of m, clamp, and register the word
  logic [STEP_W-1:0] u_step;
  logic [PN_W-1:0]   pn;
  logic              p_ovf;
  logic [W-1:0]      out_param;
  logic [W-1:0]      out_first;
  logic [W-1:0]      out_second;
  logic              out_sat;
  logic              out_clamped;

  assign u_step = (ud_side.big || (ud_quo > STEP_CAP)) ? STEP_CAP : ud_quo;
  assign pn     = ud_side.mn[W-1] ? (PN_W'(ud_side.p1) + PN_W'(u_step))
                                  : (PN_W'(ud_side.p1) - PN_W'(u_step));
  assign p_ovf  = (pn[PN_W-1:W-1] != '0) && (pn[PN_W-1:W-1] != '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ud_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_param  <= p_ovf ? (pn[PN_W-1] ? S_MIN : S_MAX) : pn[W-1:0];
      out_first  <= ud_side.mn;
      out_second <= ud_side.vn;
      out_sat    <= ud_side.sat | p_ovf;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_second, out_first, out_param};
  assign m_tuser  = out_sat;

  // some field sits at a bound of its range
  assign out_clamped = (out_param == S_MAX) || (out_param == S_MIN) ||
                       (out_first == S_MAX) || (out_first == S_MIN) ||
                       (out_second == '1);

  `ADAMW_ASSERT_ALWAYS(a_sqrt_lanes_aligned, sqv_valid == sqd_valid, "sqrt lanes out of step")
  `ADAMW_ASSERT_IMPLY(a_bias_root_nonzero, sqd_valid, sqd_root != '0, "zero bias root")
  `ADAMW_ASSERT_IMPLY(a_step_den_nonzero, m2_valid, m2_den != '0, "zero step divisor")
  `ADAMW_ASSERT_IMPLY(a_sat_at_bound, out_valid && out_sat, out_clamped, "saturation w/o clamp")

endmodule
